[rtl/core/sc3d_pkg.sv]
// ---------------------------------------------------------------------------
// sc3d_pkg: shared types and constants
// Field widths, internal arithmetic widths, item codes and the transaction
// record passed from the front end to the test pipeline.
// ---------------------------------------------------------------------------
package sc3d_pkg;

    localparam int CW   = 32;   // coordinate, Q15.16
    localparam int DW   = 16;   // direction, Q1.14
    localparam int LW   = 31;   // length / tolerance, Q15.16
    localparam int PW   = 33;   // point offset, Q.16
    localparam int MW   = 49;   // direction times offset, Q.30
    localparam int TW   = 51;   // projection sum, Q.30
    localparam int SW   = 52;   // projection compare width
    localparam int OVW  = 46;   // overlap, Q.30
    localparam int T16W = 38;   // rounded projection, Q.16
    localparam int PRW  = 54;   // rounded projection times direction, Q.30
    localparam int XW   = 55;   // perpendicular component, Q.30
    localparam int RW   = 56;   // perpendicular component plus half
    localparam int AW   = 42;   // perpendicular component, Q.16
    localparam int QW   = 62;   // square, Q.32
    localparam int SUMW = 64;   // sum of three squares

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [LW-1:0] TOL_RESET = LW'(65536);

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_TEST = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        VERDICT_MATCH    = 2'd0,
        VERDICT_OPPOSITE = 2'd1,
        VERDICT_OVERLAP  = 2'd2,
        VERDICT_FAR      = 2'd3
    } verdict_t;

    typedef struct packed {
        logic [2:0][CW-1:0] cs;
        logic [2:0][CW-1:0] ce;
        logic [2:0][DW-1:0] cd;
        logic [LW-1:0]      clen;
        logic [2:0][CW-1:0] rs;
        logic [2:0][CW-1:0] re;
        logic [2:0][DW-1:0] rd;
        logic [LW-1:0]      rlen;
    } item_t;

    typedef struct packed {
        logic  push;
        item_t data;
    } push_t;

endpackage

[rtl/core/segment3d_coincidence_test.sv]
// An accepted test transaction goes through the queue, the test pipeline and the result register to its result.
// Throughput: one transaction per cycle; the eight-stage test pipeline and
// the result register all advance together while the output is not stalled.
// Load transactions give no result and update the reference at acceptance.
// Reset (rst_n low, asynchronous) clears the reference, the queue and all
// valid flags, and sets the tolerance to 1.0.
// ---------------------------------------------------------------------------
// segment3d_coincidence_test: 3D segment coincidence test
// Front end, four-entry queue and test pipeline; holds the tolerance register.
// ---------------------------------------------------------------------------
module segment3d_coincidence_test
    import sc3d_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               kind,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic signed [31:0] start_z,
    input  logic signed [31:0] end_x,
    input  logic signed [31:0] end_y,
    input  logic signed [31:0] end_z,
    input  logic signed [15:0] dir_x,
    input  logic signed [15:0] dir_y,
    input  logic signed [15:0] dir_z,
    input  logic [30:0]        seg_length,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               is_coincident,
    output logic [1:0]         verdict,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [30:0]        pos_tolerance
);

    logic [LW-1:0] tol_reg;
    push_t         wr;
    logic          q_full, q_valid, q_pop;
    item_t         q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= TOL_RESET;
        else if (cfg_valid && cfg_ready)
            tol_reg <= pos_tolerance;
    end

    sc3d_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .kind     (kind),
        .cs       ({start_z, start_y, start_x}),
        .ce       ({end_z, end_y, end_x}),
        .cd       ({dir_z, dir_y, dir_x}),
        .clen     (seg_length),
        .q_full   (q_full),
        .wr       (wr)
    );

    sc3d_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (q_head)
    );

    sc3d_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .tol           (tol_reg),
        .q_valid       (q_valid),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .is_coincident (is_coincident),
        .verdict       (verdict)
    );

endmodule

[rtl/core/sc3d_queue.sv]
// ---------------------------------------------------------------------------
// sc3d_queue: decoupling queue
// Small register FIFO between the front end and the test pipeline.
// ---------------------------------------------------------------------------
module sc3d_queue
    import sc3d_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t wr,
    input  logic  pop,
    output logic  full,
    output logic  not_empty,
    output item_t head
);

    item_t            mem_reg [QDEPTH];
    logic [QAW-1:0]   wptr_reg, wptr_next;
    logic [QAW-1:0]   rptr_reg, rptr_next;
    logic [QAW:0]     count_reg, count_next;
    logic             do_pop;

    assign full      = (count_reg == (QAW+1)'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rptr_reg];
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wptr_next  = wptr_reg + QAW'(wr.push);
        rptr_next  = rptr_reg + QAW'(do_pop);
        count_next = count_reg + (QAW+1)'(wr.push) - (QAW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.push)
            mem_reg[wptr_reg] <= wr.data;
    end

endmodule

[rtl/core/sc3d_front.sv]
// ---------------------------------------------------------------------------
// sc3d_front: input front end
// Accepts transactions, stores the reference on loads and pushes each test
// together with the reference it sees into the queue.
// ---------------------------------------------------------------------------
module sc3d_front
    import sc3d_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               kind,
    input  logic [2:0][CW-1:0] cs,
    input  logic [2:0][CW-1:0] ce,
    input  logic [2:0][DW-1:0] cd,
    input  logic [LW-1:0]      clen,
    input  logic               q_full,
    output push_t              wr
);

    logic [2:0][CW-1:0] rs_reg;
    logic [2:0][CW-1:0] re_reg;
    logic [2:0][DW-1:0] rd_reg;
    logic [LW-1:0]      rlen_reg;
    logic               accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        wr.push      = accept && (kind == KIND_TEST);
        wr.data.cs   = cs;
        wr.data.ce   = ce;
        wr.data.cd   = cd;
        wr.data.clen = clen;
        wr.data.rs   = rs_reg;
        wr.data.re   = re_reg;
        wr.data.rd   = rd_reg;
        wr.data.rlen = rlen_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_reg   <= '0;
            re_reg   <= '0;
            rd_reg   <= '0;
            rlen_reg <= '0;
        end
        else if (accept && (kind == KIND_LOAD))
        begin
            rs_reg   <= cs;
            re_reg   <= ce;
            rd_reg   <= cd;
            rlen_reg <= clen;
        end
    end

endmodule

[rtl/core/sc3d_back.sv]
// ---------------------------------------------------------------------------
// sc3d_back: test pipeline
// Eight registered stages plus the result register: offsets, projections,
// overlap, end selection, rounding, perpendicular components, squares.
// ---------------------------------------------------------------------------
module sc3d_back
    import sc3d_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic [LW-1:0] tol,
    input  logic          q_valid,
    input  item_t         q_head,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic          is_coincident,
    output logic [1:0]    verdict
);

    logic en;
    logic [7:0] v_reg;

    // stage 1
    logic signed [PW-1:0] p1_s1 [3], p2_s1 [3], w1_s1 [3], w2_s1 [3];
    logic signed [DW-1:0] cd_s1 [3], rd_s1 [3];
    logic signed [2*DW-1:0] dd_s1 [3];
    logic [LW-1:0] clen_s1, rlen_s1;
    // stage 2
    logic signed [PW-1:0] p1_s2 [3], p2_s2 [3], w1_s2 [3], w2_s2 [3];
    logic signed [DW-1:0] cd_s2 [3], rd_s2 [3];
    logic signed [MW-1:0] md1_s2 [3], md2_s2 [3], mt1_s2 [3], mt2_s2 [3];
    logic [LW-1:0] clen_s2, rlen_s2;
    logic opp_s2;
    // stage 3
    logic signed [PW-1:0] p1_s3 [3], p2_s3 [3], w1_s3 [3], w2_s3 [3];
    logic signed [DW-1:0] cd_s3 [3], rd_s3 [3];
    logic signed [TW-1:0] d1_s3, d2_s3, t1_s3, t2_s3;
    logic [LW-1:0] clen_s3, rlen_s3;
    logic opp_s3;
    // stage 4: per end
    logic signed [PW-1:0] off_s4 [2][3];
    logic signed [DW-1:0] dir_s4 [2][3];
    logic signed [TW-1:0] t_s4 [2];
    logic [OVW-1:0] ov_s4;
    logic [LW-1:0]  minlen_s4;
    logic opp_s4;
    // stage 5
    logic signed [PW-1:0]   off_s5 [2][3];
    logic signed [DW-1:0]   dir_s5 [2][3];
    logic signed [T16W-1:0] t16_s5 [2];
    logic opp_s5, few_s5;
    // stage 6
    logic signed [PW-1:0]  off_s6 [2][3];
    logic signed [PRW-1:0] pr_s6 [2][3];
    logic opp_s6, few_s6;
    // stage 7
    logic [LW-1:0] a_s7 [2][3];
    logic [1:0] big_s7;
    logic opp_s7, few_s7;
    // stage 8
    logic [QW-1:0] sq_s8 [2][3];
    logic [QW-1:0] tol2_s8;
    logic [1:0] big_s8;
    logic opp_s8, few_s8;

    // combinational helpers
    logic signed [SW-1:0]  lo_c, hi_c, len30_c, a_c, b_c;
    logic                  lo_neg_c, hi_over_c;
    logic [OVW-1:0]        ov_c;
    logic signed [SW-1:0]  tr_c [2];
    logic signed [XW-1:0]  x_c [2][3];
    logic signed [RW-1:0]  xr_c [2][3];
    logic signed [AW-1:0]  c_c [2][3];
    logic [AW-1:0]         abs_c [2][3];
    logic [1:0]            big_c;
    logic [SUMW-1:0]       sum_c [2];
    logic [1:0]            near_c;
    verdict_t              verdict_c;

    logic       out_valid_reg;
    logic       is_coincident_reg;
    logic [1:0] verdict_reg;

    // advance the whole pipeline whenever the result register can take data
    assign en        = !out_valid_reg || !out_stall;
    assign q_pop     = en;
    assign out_valid = out_valid_reg;
    assign is_coincident = is_coincident_reg;
    assign verdict   = verdict_reg;

    always_comb
    begin
        lo_c      = (d1_s3 < d2_s3) ? SW'(d1_s3) : SW'(d2_s3);
        hi_c      = (d1_s3 < d2_s3) ? SW'(d2_s3) : SW'(d1_s3);
        len30_c   = $signed({(SW-LW-14)'(0), rlen_s3, 14'b0});
        lo_neg_c  = lo_c < 0;
        hi_over_c = hi_c > len30_c;
        a_c       = lo_neg_c ? '0 : lo_c;
        b_c       = hi_over_c ? len30_c : hi_c;
        if (lo_c > len30_c || hi_c < 0)
            ov_c = '0;
        else
            ov_c = OVW'(b_c - a_c);
    end

    always_comb
    begin
        for (int e = 0; e < 2; e++)
        begin
            tr_c[e] = SW'(t_s4[e]) + SW'(8192);
            big_c[e] = 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                x_c[e][i]  = XW'($signed({off_s6[e][i], 14'b0})) - XW'(pr_s6[e][i]);
                xr_c[e][i] = RW'(x_c[e][i]) + RW'(8192);
                c_c[e][i]  = xr_c[e][i][RW-1:14];
                abs_c[e][i] = c_c[e][i][AW-1] ? AW'(-c_c[e][i]) : AW'(c_c[e][i]);
                if (abs_c[e][i] >= AW'(tol))
                    big_c[e] = 1'b1;
            end
            sum_c[e]  = SUMW'(sq_s8[e][0]) + SUMW'(sq_s8[e][1]) + SUMW'(sq_s8[e][2]);
            near_c[e] = !big_s8[e] && (sum_c[e] < SUMW'(tol2_s8));
        end
        if (opp_s8)
            verdict_c = VERDICT_OPPOSITE;
        else if (few_s8)
            verdict_c = VERDICT_OVERLAP;
        else if (near_c[0] && near_c[1])
            verdict_c = VERDICT_MATCH;
        else
            verdict_c = VERDICT_FAR;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg         <= {v_reg[6:0], q_valid};
            out_valid_reg <= v_reg[7];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1: offsets and direction products
            for (int i = 0; i < 3; i++)
            begin
                p1_s1[i] <= PW'($signed(q_head.cs[i])) - PW'($signed(q_head.rs[i]));
                p2_s1[i] <= PW'($signed(q_head.ce[i])) - PW'($signed(q_head.rs[i]));
                w1_s1[i] <= PW'($signed(q_head.rs[i])) - PW'($signed(q_head.cs[i]));
                w2_s1[i] <= PW'($signed(q_head.re[i])) - PW'($signed(q_head.cs[i]));
                cd_s1[i] <= $signed(q_head.cd[i]);
                rd_s1[i] <= $signed(q_head.rd[i]);
                dd_s1[i] <= $signed(q_head.cd[i]) * $signed(q_head.rd[i]);
            end
            clen_s1 <= q_head.clen;
            rlen_s1 <= q_head.rlen;

            // stage 2: projection products
            for (int i = 0; i < 3; i++)
            begin
                md1_s2[i] <= rd_s1[i] * p1_s1[i];
                md2_s2[i] <= rd_s1[i] * p2_s1[i];
                mt1_s2[i] <= w1_s1[i] * cd_s1[i];
                mt2_s2[i] <= w2_s1[i] * cd_s1[i];
            end
            opp_s2  <= (34'(dd_s1[0]) + 34'(dd_s1[1]) + 34'(dd_s1[2])) < 0;
            p1_s2 <= p1_s1; p2_s2 <= p2_s1; w1_s2 <= w1_s1; w2_s2 <= w2_s1;
            cd_s2 <= cd_s1; rd_s2 <= rd_s1;
            clen_s2 <= clen_s1; rlen_s2 <= rlen_s1;

            // stage 3: projection sums
            d1_s3 <= TW'(md1_s2[0]) + TW'(md1_s2[1]) + TW'(md1_s2[2]);
            d2_s3 <= TW'(md2_s2[0]) + TW'(md2_s2[1]) + TW'(md2_s2[2]);
            t1_s3 <= TW'(mt1_s2[0]) + TW'(mt1_s2[1]) + TW'(mt1_s2[2]);
            t2_s3 <= TW'(mt2_s2[0]) + TW'(mt2_s2[1]) + TW'(mt2_s2[2]);
            p1_s3 <= p1_s2; p2_s3 <= p2_s2; w1_s3 <= w1_s2; w2_s3 <= w2_s2;
            cd_s3 <= cd_s2; rd_s3 <= rd_s2;
            clen_s3 <= clen_s2; rlen_s3 <= rlen_s2;
            opp_s3 <= opp_s2;

            // stage 4: overlap and end selection
            // near end keeps the start offset and far end the end offset
            ov_s4     <= ov_c;
            minlen_s4 <= (rlen_s3 < clen_s3) ? rlen_s3 : clen_s3;
            t_s4[0]   <= lo_neg_c ? t1_s3 : TW'(lo_c);
            t_s4[1]   <= hi_over_c ? t2_s3 : TW'(hi_c);
            for (int i = 0; i < 3; i++)
            begin
                off_s4[0][i] <= lo_neg_c ? w1_s3[i] : p1_s3[i];
                dir_s4[0][i] <= lo_neg_c ? cd_s3[i] : rd_s3[i];
                off_s4[1][i] <= hi_over_c ? w2_s3[i] : p2_s3[i];
                dir_s4[1][i] <= hi_over_c ? cd_s3[i] : rd_s3[i];
            end
            opp_s4 <= opp_s3;

            // stage 5: overlap check and projection rounding
            few_s5 <= {ov_s4, 1'b0} < {2'b0, minlen_s4, 14'b0};
            for (int e = 0; e < 2; e++)
                t16_s5[e] <= tr_c[e][SW-1:14];
            off_s5 <= off_s4;
            dir_s5 <= dir_s4;
            opp_s5 <= opp_s4;

            // stage 6: projection times direction
            for (int e = 0; e < 2; e++)
                for (int i = 0; i < 3; i++)
                    pr_s6[e][i] <= t16_s5[e] * dir_s5[e][i];
            off_s6 <= off_s5;
            opp_s6 <= opp_s5;
            few_s6 <= few_s5;

            // stage 7: perpendicular components
            for (int e = 0; e < 2; e++)
                for (int i = 0; i < 3; i++)
                    a_s7[e][i] <= abs_c[e][i][LW-1:0];
            big_s7 <= big_c;
            opp_s7 <= opp_s6;
            few_s7 <= few_s6;

            // stage 8: squares
            for (int e = 0; e < 2; e++)
                for (int i = 0; i < 3; i++)
                    sq_s8[e][i] <= a_s7[e][i] * a_s7[e][i];
            tol2_s8 <= tol * tol;
            big_s8  <= big_s7;
            opp_s8  <= opp_s7;
            few_s8  <= few_s7;

            // result register
            is_coincident_reg <= (verdict_c == VERDICT_MATCH);
            verdict_reg       <= verdict_c;
        end
    end

endmodule

[rtl/core/sc3d_checker.sv]
// ---------------------------------------------------------------------------
// sc3d_checker: port-level checks
// Watches the top-level ports and is bound to the top level.
// ---------------------------------------------------------------------------
module sc3d_checker
    import sc3d_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       is_coincident,
    input logic [1:0] verdict,
    input logic       cfg_ready
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(verdict) && $stable(is_coincident))
        else $error("stalled result changed");

    a_flag_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_coincident == (verdict == VERDICT_MATCH)))
        else $error("coincidence flag disagrees with verdict");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result shown during reset");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind segment3d_coincidence_test sc3d_checker u_sc3d_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .is_coincident (is_coincident),
    .verdict       (verdict),
    .cfg_ready     (cfg_ready)
);

[test/sc3d_coincidence_check.sv]
// ---------------------------------------------------------------------------
// sc3d_coincidence_check: prediction and scoreboard for the coincidence test
// Watches the input, output and tolerance channels. Keeps its own copy of the
// reference segment and tolerance, predicts the verdict of every accepted test
// transaction and compares each accepted result with the oldest prediction.
// ---------------------------------------------------------------------------
module sc3d_coincidence_check
    import sc3d_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               kind,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic signed [31:0] start_z,
    input  logic signed [31:0] end_x,
    input  logic signed [31:0] end_y,
    input  logic signed [31:0] end_z,
    input  logic signed [15:0] dir_x,
    input  logic signed [15:0] dir_y,
    input  logic signed [15:0] dir_z,
    input  logic [30:0]        seg_length,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic               is_coincident,
    input  logic [1:0]         verdict,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [30:0]        pos_tolerance,
    output int                 errors,
    output int                 pending,
    output int                 results,
    output int                 hits
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef longint vec3_t [3];

    vec3_t          ref_s, ref_e, ref_d;
    longint         ref_len;
    longint unsigned tol;
    verdict_t       verdict_q[$];

    // Q.30 to Q.16: add half, floor
    function automatic longint to_q16(longint x);
        return (x + 64'sd8192) >>> 14;
    endfunction

    function automatic longint dot(vec3_t a, vec3_t b);
        return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    // true when |off - t*dir|^2 < tol^2
    function automatic bit within_tol(vec3_t off, longint t, vec3_t dir,
                                      longint unsigned lim);
        longint t16;
        longint c;
        longint unsigned mag;
        longint unsigned sum;
        t16 = to_q16(t);
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            c = to_q16(off[i] * 16384 - t16 * dir[i]);
            mag = (c < 0) ? longint'(-c) : longint'(c);
            if (mag >= lim)
                return 1'b0;
            sum += mag * mag;
        end
        return sum < lim * lim;
    endfunction

    function automatic verdict_t grade(vec3_t cs, vec3_t ce, vec3_t cd, longint clen);
        vec3_t  p1, p2, w;
        longint d1, d2, lo, hi, len30, ov, minlen;
        bit     ok1, ok2;
        if (dot(ref_d, cd) < 0)
            return VERDICT_OPPOSITE;
        for (int i = 0; i < 3; i++)
        begin
            p1[i] = cs[i] - ref_s[i];
            p2[i] = ce[i] - ref_s[i];
        end
        d1 = dot(ref_d, p1);
        d2 = dot(ref_d, p2);
        lo = (d1 < d2) ? d1 : d2;
        hi = (d1 < d2) ? d2 : d1;
        len30 = ref_len * 16384;
        if (lo > len30 || hi < 0)
            ov = 0;
        else
            ov = ((hi > len30) ? len30 : hi) - ((lo < 0) ? 0 : lo);
        minlen = ((ref_len < clen) ? ref_len : clen) * 16384;
        if (2 * ov < minlen)
            return VERDICT_OVERLAP;
        // near end: distance to the candidate line when it starts before the reference
        if (lo < 0)
        begin
            for (int i = 0; i < 3; i++)
                w[i] = ref_s[i] - cs[i];
            ok1 = within_tol(w, dot(w, cd), cd, tol);
        end
        else
            ok1 = within_tol(p1, lo, ref_d, tol);
        if (hi > len30)
        begin
            for (int i = 0; i < 3; i++)
                w[i] = ref_e[i] - cs[i];
            ok2 = within_tol(w, dot(w, cd), cd, tol);
        end
        else
            ok2 = within_tol(p2, hi, ref_d, tol);
        return (ok1 && ok2) ? VERDICT_MATCH : VERDICT_FAR;
    endfunction

    assign pending = verdict_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        vec3_t    cs, ce, cd;
        verdict_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ref_s[i] = 0;
                ref_e[i] = 0;
                ref_d[i] = 0;
            end
            ref_len = 0;
            tol     = 65536;
            errors  <= 0;
            results <= 0;
            hits    <= 0;
            verdict_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                tol = longint'(pos_tolerance);
            if (in_valid && !in_stall)
            begin
                cs = '{longint'(start_x), longint'(start_y), longint'(start_z)};
                ce = '{longint'(end_x), longint'(end_y), longint'(end_z)};
                cd = '{longint'(dir_x), longint'(dir_y), longint'(dir_z)};
                if (kind == KIND_LOAD)
                begin
                    ref_s   = cs;
                    ref_e   = ce;
                    ref_d   = cd;
                    ref_len = longint'(seg_length);
                end
                else
                    verdict_q.push_back(grade(cs, ce, cd, longint'(seg_length)));
            end
            if (out_valid && !out_stall)
            begin
                results <= results + 1;
                if (verdict_q.size() == 0)
                begin
                    $error("result transaction with no test pending");
                    errors <= errors + 1;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (want == VERDICT_MATCH)
                        hits <= hits + 1;
                    if (verdict !== want)
                    begin
                        $error("verdict: expected %0d, actual %0d", want, verdict);
                        errors <= errors + 1;
                    end
                    else if (is_coincident !== (want == VERDICT_MATCH))
                    begin
                        $error("is_coincident: expected %0d, actual %0d",
                               want == VERDICT_MATCH, is_coincident);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

[test/tb_segment3d_coincidence_test.sv]
// ---------------------------------------------------------------------------
// tb_segment3d_coincidence_test: stimulus and verdict for the coincidence test
// Directed corner transactions, then phases of random reference loads and
// candidate tests at several tolerances, with random stalls on both sides in all but the last phase.
// ---------------------------------------------------------------------------
module tb_segment3d_coincidence_test;
    timeunit 1ns;
    timeprecision 1ps;
    import sc3d_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               kind = 1'b0;
    logic signed [31:0] start_x = '0, start_y = '0, start_z = '0;
    logic signed [31:0] end_x = '0, end_y = '0, end_z = '0;
    logic signed [15:0] dir_x = '0, dir_y = '0, dir_z = '0;
    logic [30:0]        seg_length = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               is_coincident;
    logic [1:0]         verdict;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [30:0]        pos_tolerance = '0;

    int  errors, pending, results, hits;
    int  sent = 0;
    int  stall_left = 0;
    bit  bursts = 1'b1;

    // reference segment of the current well-formed sequence
    longint rs[3], rd[3], rl;

    always #4 clk = ~clk;

    segment3d_coincidence_test DUT (.*);

    sc3d_coincidence_check u_check (.*);

    initial
    begin
        #5ms;
        $display("[segment3d_coincidence_test] ERROR");
        $finish;
    end

    // random receiver stall bursts while bursts is set
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (bursts && $urandom_range(0, 4) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 4);
        end
        else
            out_stall <= 1'b0;
    end

    task automatic send(kind_t k, longint sx, longint sy, longint sz,
                        longint ex, longint ey, longint ez,
                        longint dx, longint dy, longint dz, longint len);
        if (bursts && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 5))
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        @(negedge clk);
        in_valid   <= 1'b1;
        kind       <= k;
        start_x    <= 32'(sx);
        start_y    <= 32'(sy);
        start_z    <= 32'(sz);
        end_x      <= 32'(ex);
        end_y      <= 32'(ey);
        end_z      <= 32'(ez);
        dir_x      <= 16'(dx);
        dir_y      <= 16'(dy);
        dir_z      <= 16'(dz);
        seg_length <= 31'(len);
        do
            @(posedge clk);
        while (in_stall);
        sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (14) @(posedge clk);
    endtask

    task automatic set_tolerance(logic [30:0] v);
        @(negedge clk);
        cfg_valid     <= 1'b1;
        pos_tolerance <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic pick_dir(output longint d[3]);
        real v[3];
        real n;
        for (int i = 0; i < 3; i++)
            v[i] = real'($urandom_range(0, 2000)) - 1000.0;
        n = $sqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]);
        if (n < 1.0)
            d = '{16384, 0, 0};
        else
            for (int i = 0; i < 3; i++)
                d[i] = $rtoi(v[i] / n * 16384.0);
    endtask

    task automatic load_reference();
        for (int i = 0; i < 3; i++)
            rs[i] = longint'($urandom_range(0, 32'h07FF_FFFF)) - 64'sh0400_0000;
        pick_dir(rd);
        rl = $urandom_range(1, 32'h003F_FFFF);
        send(KIND_LOAD, rs[0], rs[1], rs[2],
             rs[0] + ((rd[0] * rl) >>> 14), rs[1] + ((rd[1] * rl) >>> 14),
             rs[2] + ((rd[2] * rl) >>> 14), rd[0], rd[1], rd[2], rl);
    endtask

    // candidate near the reference line with random offset, length and skew, sometimes reversed
    task automatic test_candidate();
        longint u, cl, k;
        longint cs[3], cd[3];
        u  = longint'($urandom_range(0, 32'(rl + rl / 2))) - rl / 2;
        cl = $urandom_range(1, 32'(rl + rl / 2 + 1));
        k  = 64'sd1 << $urandom_range(4, 19);
        for (int i = 0; i < 3; i++)
        begin
            cs[i] = rs[i] + ((rd[i] * u) >>> 14)
                    + longint'($urandom_range(0, 32'(2 * k))) - k;
            cd[i] = rd[i];
        end
        case ($urandom_range(0, 9))
            0: for (int i = 0; i < 3; i++) cd[i] = -rd[i];
            1: for (int i = 0; i < 3; i++) cd[i] = rd[i] + $urandom_range(0, 400) - 200;
            default: ;
        endcase
        send(KIND_TEST, cs[0], cs[1], cs[2],
             cs[0] + ((cd[0] * cl) >>> 14), cs[1] + ((cd[1] * cl) >>> 14),
             cs[2] + ((cd[2] * cl) >>> 14), cd[0], cd[1], cd[2], cl);
    endtask

    task automatic noise_item();
        send(kind_t'($urandom_range(0, 1)),
             longint'(int'($urandom)), longint'(int'($urandom)), longint'(int'($urandom)),
             longint'(int'($urandom)), longint'(int'($urandom)), longint'(int'($urandom)),
             longint'(shortint'($urandom)), longint'(shortint'($urandom)),
             longint'(shortint'($urandom)), $urandom & 32'h7FFF_FFFF);
    endtask

    initial
    begin
        logic [30:0] tols[6];
        tols = '{31'd0, 31'h7FFF_FFFF, 31'd1, 31'd262144, 31'd4096, 31'd65536};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // test before any load, against the all-zero reference
        send(KIND_TEST, 0, 0, 0, 65536, 0, 0, 16384, 0, 0, 65536);
        send(KIND_TEST, -1, 5, 7, 9, 3, 2, -16384, 16384, 0, 0);
        // unit reference along x, length 10
        send(KIND_LOAD, 0, 0, 0, 655360, 0, 0, 16384, 0, 0, 655360);
        send(KIND_TEST, 0, 0, 0, 655360, 0, 0, 16384, 0, 0, 655360);
        send(KIND_TEST, 655360, 0, 0, 0, 0, 0, -16384, 0, 0, 655360);
        send(KIND_TEST, 0, 0, 0, 655360, 0, 0, 0, 16384, 0, 655360);
        send(KIND_TEST, 600000, 0, 0, 1255360, 0, 0, 16384, 0, 0, 655360);
        send(KIND_TEST, 0, 65535, 0, 655360, 65535, 0, 16384, 0, 0, 655360);
        send(KIND_TEST, 0, 65536, 0, 655360, 65536, 0, 16384, 0, 0, 655360);
        send(KIND_TEST, -327680, 100, 0, 983040, -100, 0, 16384, 0, 0, 1310720);
        send(KIND_TEST, 0, 0, 0, 0, 0, 0, 16384, 0, 0, 0);
        send(KIND_TEST, 1000, 70000000, -70000000, 2000, 70000000, -70000000,
             16384, 0, 0, 655360);
        // extremes of every field
        send(KIND_LOAD, -64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000,
             64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 16384, 16384, 16384,
             64'h7FFF_FFFF);
        send(KIND_TEST, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF,
             -64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000, -16384, -16384, -16384,
             64'h7FFF_FFFF);
        send(KIND_TEST, -64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000,
             64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 16384, 16384, 16384, 0);
        send(KIND_TEST, 0, 0, 0, 0, 0, 0, -32768, 32767, -32768, 64'h7FFF_FFFF);
        drain();

        for (int p = 0; p < 6; p++)
        begin
            set_tolerance(p == 3 ? 31'($urandom_range(1, 32'h0010_0000)) : tols[p]);
            bursts = (p != 5);
            repeat (14)
            begin
                load_reference();
                repeat ($urandom_range(8, 14))
                begin
                    if ($urandom_range(0, 9) == 0)
                        noise_item();
                    else
                        test_candidate();
                end
            end
            drain();
        end

        $display("Sent %0d transactions, checked %0d results (%0d matches), %0d errors",
                 sent, results, hits, errors);
        $display("Tolerances covered: reset, zero, one, full scale and random");
        if (errors == 0)
            $display("[segment3d_coincidence_test] OK");
        else
            $display("[segment3d_coincidence_test] ERROR");
        $finish;
    end

endmodule
